/* rtl/pcg_pkg.sv */
// ----------------------------------------------------------------------------
// pcg_pkg
// shared constants, register indexes, format codes and the oetf table builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcg_pkg;

  localparam int unsigned REG_W       = 14;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned POS_W       = 13;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IN_DATA_W   = 64;
  localparam int unsigned OUT_DATA_W  = 24;

  localparam logic [REG_W-1:0] MAX_DIM = 14'd8192;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd5;

  localparam logic [1:0] FMT_8BIT  = 2'd0;
  localparam logic [1:0] FMT_10BIT = 2'd1;
  localparam logic [1:0] FMT_12BIT = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  // lut layout: 12-bit curve in the first 4096 entries, 10-bit curve after it
  localparam int unsigned LUT_DEPTH  = 5120;
  localparam int unsigned LUT_ADDR_W = 13;
  localparam int unsigned LUT10_BASE = 4096;

  // largest r with (1000r - 500 + 99m)^20 <= 1099^20 * m^11 * n^9, from r up
  function automatic int unsigned oetf_search(int unsigned m, int unsigned n,
                                              int unsigned r_start);
    logic [511:0] rhs;
    logic [511:0] lhs;
    int unsigned  a;
    int unsigned  r;
    int           i;
    logic         done;
    rhs = 512'd1;
    for (i = 0; i < 20; i++) rhs = rhs * 512'(1099);
    for (i = 0; i < 11; i++) rhs = rhs * 512'(m);
    for (i = 0; i < 9; i++) rhs = rhs * 512'(n);
    r = r_start;
    done = 1'b0;
    while (!done) begin
      a = 1000 * (r + 1) - 500 + 99 * m;
      lhs = 512'd1;
      for (i = 0; i < 20; i++) lhs = lhs * 512'(a);
      if (lhs <= rhs) begin
        r = r + 1;
      end else begin
        done = 1'b1;
      end
    end
    return r;
  endfunction

  // final output byte for code n, already shifted down to 8 bits
  // r carries the running search point, codes are taken in rising order
  function automatic logic [BYTE_W-1:0] oetf_byte(int unsigned depth, int unsigned n,
                                                 inout int unsigned r);
    int unsigned m;
    int unsigned val;
    m = (1 << depth) - 1;
    if (n * 1000 < 18 * m) begin
      val = (9 * n + 1) >> 1;
    end else begin
      r   = oetf_search(m, n, r);
      val = r;
    end
    return BYTE_W'((val >> (depth - 8)) & 255);
  endfunction

endpackage

`default_nettype wire

/* rtl/pcg_rom.sv */
// ----------------------------------------------------------------------------
// pcg_rom
// one-port synchronous oetf rom, registered read with read enable
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcg_rom (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [pcg_pkg::LUT_ADDR_W-1:0] rd_addr,
  output logic      [pcg_pkg::BYTE_W-1:0]     rd_data
);
  import pcg_pkg::*;

  logic [BYTE_W-1:0] rom [LUT_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  initial begin : fill_rom
    int unsigned r10;
    int unsigned r12;
    int unsigned n;
    r10 = 0;
    r12 = 0;
    for (n = 0; n < 4096; n++) rom[LUT_ADDR_W'(n)] = oetf_byte(12, n, r12);
    for (n = 0; n < 1024; n++) rom[LUT_ADDR_W'(LUT10_BASE + n)] = oetf_byte(10, n, r10);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/pixel_crop_gamma_to_rgb888.sv */
// ----------------------------------------------------------------------------
// pixel_crop_gamma_to_rgb888
// clip rectangle crop, optional bt.709 oetf and reduction to bgr888
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in_      in   tvalid / tready    column, row, red, green, blue
// out_     out  tvalid / tready    out_blue, out_green, out_red
// cfg_     in   wr_en              index 0..5, 14-bit data
//
// one item per clock sustained while out_tready is high
// an item goes through the registered oetf rom read, then the output register
// reset clears the valid flags and loads the register reset values
// an item outside the rectangle is taken and gives no result
// a waiting result sits in the output register while the next item is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_crop_gamma_to_rgb888 (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // column[12:0], row[25:13], red[37:26], green[49:38], blue[61:50], zero[63:62]
  input  wire logic [pcg_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_blue[7:0], out_green[15:8], out_red[23:16]
  output logic      [pcg_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcg_pkg::REG_W-1:0]         cfg_wdata
);
  import pcg_pkg::*;

  logic [1:0]       fmt_r;
  logic             gamma_r;
  logic [REG_W-1:0] left_r, top_r, right_r, bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_8BIT;
      gamma_r  <= 1'b0;
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= MAX_DIM;
      bottom_r <= MAX_DIM;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: fmt_r    <= cfg_wdata[1:0];
        REG_GAMMA_ENABLE: gamma_r  <= cfg_wdata[0];
        REG_CLIP_LEFT:    left_r   <= cfg_wdata;
        REG_CLIP_TOP:     top_r    <= cfg_wdata;
        REG_CLIP_RIGHT:   right_r  <= cfg_wdata;
        REG_CLIP_BOTTOM:  bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [POS_W-1:0]    col, row;
  logic [SAMPLE_W-1:0] smp [3];

  assign col    = in_tdata[12:0];
  assign row    = in_tdata[25:13];
  assign smp[0] = in_tdata[61:50];
  assign smp[1] = in_tdata[49:38];
  assign smp[2] = in_tdata[37:26];

  logic keep, use_lut;

  assign keep = (fmt_r != FMT_NONE)
             && ({1'b0, col} >= left_r) && ({1'b0, col} < right_r)
             && ({1'b0, row} >= top_r)  && ({1'b0, row} < bottom_r);
  assign use_lut = gamma_r && ((fmt_r == FMT_10BIT) || (fmt_r == FMT_12BIT));

  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_lut_r;
  logic [BYTE_W-1:0]   s1_pass_r [3];
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                in_fire, out_load, s1_en;
  logic [BYTE_W-1:0]   rom_q [3];
  logic [LUT_ADDR_W-1:0] rom_addr [3];

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_en     = !s1_valid_r || out_load;
  assign in_tready = s1_en;
  assign in_fire   = in_tvalid && in_tready;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign rom_addr[c] = (fmt_r == FMT_10BIT)
                       ? LUT_ADDR_W'(LUT10_BASE + {22'd0, smp[c][9:0]})
                       : {1'b0, smp[c]};

    pcg_rom u_rom (
      .clk     (clk),
      .rd_en   (s1_en),
      .rd_addr (rom_addr[c]),
      .rd_data (rom_q[c])
    );

    always_ff @(posedge clk) begin
      if (s1_en) begin
        case (fmt_r)
          FMT_10BIT: s1_pass_r[c] <= smp[c][9:2];
          FMT_12BIT: s1_pass_r[c] <= smp[c][11:4];
          default:   s1_pass_r[c] <= smp[c][7:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_lut_r <= use_lut;
    end
    if (out_load) begin
      out_data_r <= s1_lut_r ? {rom_q[2], rom_q[1], rom_q[0]}
                             : {s1_pass_r[2], s1_pass_r[1], s1_pass_r[0]};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_en ? (in_fire && keep) : s1_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fmt_none_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (fmt_r == FMT_NONE) |=> !s1_valid_r)
    else $error("pixel taken with unused format reached the lut stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r && $stable(s1_lut_r))
    else $error("stalled lut stage item lost");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("item taken with both stages full");

  a_out_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_tready)
    else $error("output register overwritten while waiting");

endmodule

`default_nettype wire
